@@ design/vucsp_pkg.sv @@
// ----------------------------------------------------------------------------
// vucsp_pkg
// Shared types, command codes and the unpack format table for the vector
// unit command stream parser.
// ----------------------------------------------------------------------------
package vucsp_pkg;

    // command codes, bits 30:24 of a command word
    localparam logic [6:0] CMD_FIELD_MASK = 7'h7F;
    localparam logic [6:0] CMD_MSCAL      = 7'h14;
    localparam logic [6:0] CMD_MSCALF     = 7'h15;
    localparam logic [6:0] CMD_MSCNT      = 7'h17;
    localparam logic [6:0] CMD_STMASK     = 7'h20;
    localparam logic [6:0] CMD_STROW      = 7'h30;
    localparam logic [6:0] CMD_STCOL      = 7'h31;
    localparam logic [6:0] CMD_DIRECT     = 7'h50;
    localparam logic [6:0] CMD_DIRECTHL   = 7'h51;
    localparam logic [6:0] CMD_UNPACK_LO  = 7'h60;
    localparam logic [6:0] CMD_UNPACK_HI  = 7'h7F;

    // unpack format that is stored to data memory (V4-32)
    localparam logic [3:0] FMT_V4_32 = 4'h0C;

    // register payload lengths in words
    localparam logic [17:0] MASK_WORDS = 18'd1;
    localparam logic [17:0] ROWCOL_WORDS = 18'd4;

    // result action codes
    typedef enum logic [2:0] {
        ACT_CONSUMED = 3'd0,
        ACT_VU_START = 3'd1,
        ACT_VU_CONT  = 3'd2,
        ACT_DIRECT   = 3'd3,
        ACT_WRITE    = 3'd4,
        ACT_DISCARD  = 3'd5
    } action_t;

    // parser state, one-hot
    typedef enum logic [4:0] {
        MODE_CMD    = 5'b00001,
        MODE_SKIP   = 5'b00010,
        MODE_DIRECT = 5'b00100,
        MODE_UNPACK = 5'b01000,
        MODE_DROP   = 5'b10000
    } mode_t;

    // one result word
    typedef struct packed {
        action_t     action;
        logic [18:0] vu_start_addr;
        logic [31:0] data_word;
        logic [13:0] mem_byte_addr;
        logic        direct_last;
    } result_t;

    // command decode outcome, applied by the parser state
    typedef struct packed {
        action_t     action;
        logic [18:0] start_addr;
        mode_t       mode;
        logic        load_count;
        logic [17:0] count;
        logic        load_unpack;
        logic [13:0] unpack_addr;
        logic        store_en;
    } decode_t;

    // bytes per vector for each unpack format
    function automatic logic [4:0] unpack_bytes(input logic [3:0] fmt);
        logic [4:0] bytes;
        case (fmt)
            4'h0:    bytes = 5'd16;
            4'h1:    bytes = 5'd16;
            4'h2:    bytes = 5'd16;
            4'h3:    bytes = 5'd16;
            4'h4:    bytes = 5'd8;
            4'h5:    bytes = 5'd4;
            4'h6:    bytes = 5'd2;
            4'h7:    bytes = 5'd16;
            4'h8:    bytes = 5'd12;
            4'h9:    bytes = 5'd6;
            4'hA:    bytes = 5'd3;
            4'hB:    bytes = 5'd16;
            4'hC:    bytes = 5'd16;
            4'hD:    bytes = 5'd8;
            4'hE:    bytes = 5'd4;
            default: bytes = 5'd2;
        endcase
        return bytes;
    endfunction

endpackage

@@ design/vucsp_if.sv @@
// ----------------------------------------------------------------------------
// vucsp interfaces
// Valid/ready channels for packet words in and parser results out.
// ----------------------------------------------------------------------------
interface vucsp_in_if import vucsp_pkg::*; ();
    logic        valid;
    logic        ready;
    logic [31:0] command_word;
    logic [17:0] words_left;

    modport source (output valid, output command_word, output words_left, input ready);
    modport sink (input valid, input command_word, input words_left, output ready);
endinterface

interface vucsp_out_if import vucsp_pkg::*; ();
    logic        valid;
    logic        ready;
    action_t     action;
    logic [18:0] vu_start_addr;
    logic [31:0] data_word;
    logic [13:0] mem_byte_addr;
    logic        direct_last;

    modport source (
        output valid, output action, output vu_start_addr, output data_word,
        output mem_byte_addr, output direct_last, input ready
    );
    modport sink (
        input valid, input action, input vu_start_addr, input data_word,
        input mem_byte_addr, input direct_last, output ready
    );
endinterface

@@ design/vector_unit_command_stream_parser_unit.sv @@
// ----------------------------------------------------------------------------
// vector_unit_command_stream_parser_unit
// Parses a DMA packet word by word into vector unit start, direct and
// unpack-write results.
// ----------------------------------------------------------------------------
// Takes one packet word per cycle and gives exactly one result word for each
// word taken, in order. A word is held in an input register, decoded
// combinationally and applied to the parser state, and its result is registered:
// a word passes the input register and then the result register, and the block
// sustains one word per cycle as long as the result side keeps taking words.
// The per-word state update (mode, payload count, unpack address) is the
// loop that sets this rate. The packet word with words_left of
// one (or zero) ends the packet and returns the parser to command decoding.
// ----------------------------------------------------------------------------
module vector_unit_command_stream_parser_unit import vucsp_pkg::*; #(
    parameter int unsigned VU_DATA_BYTES = 16384
) (
    input  logic        clk,
    input  logic        rst_n,
    vucsp_in_if.sink    packet,
    vucsp_out_if.source result
);

    logic        in_valid_reg;
    logic [31:0] in_word_reg;
    logic [17:0] in_left_reg;

    mode_t       mode_reg;
    mode_t       mode_next;
    logic [17:0] cnt_reg;
    logic [17:0] cnt_next;
    logic [13:0] waddr_reg;
    logic [13:0] waddr_next;
    logic        store_reg;
    logic        store_next;

    decode_t     dec;
    result_t     res;
    logic        out_free;
    logic        advance;
    logic        pkt_end;

    // handshake between the input register and the result register
    assign advance      = in_valid_reg && out_free;
    assign packet.ready = !in_valid_reg || advance;
    assign pkt_end      = (in_left_reg <= 18'd1);

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (packet.ready)
        begin
            in_valid_reg <= packet.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (packet.valid && packet.ready)
        begin
            in_word_reg <= packet.command_word;
            in_left_reg <= packet.words_left;
        end
    end

    // command decoder
    vucsp_decode #(
        .VU_DATA_BYTES (VU_DATA_BYTES)
    ) u_decode (
        .word       (in_word_reg),
        .words_left (in_left_reg),
        .dec        (dec)
    );

    // per-word parser step
    always_comb
    begin
        mode_next  = mode_reg;
        cnt_next   = cnt_reg;
        waddr_next = waddr_reg;
        store_next = store_reg;
        res        = '0;
        res.action = ACT_CONSUMED;
        unique case (mode_reg)
            MODE_SKIP:
            begin
                cnt_next = cnt_reg - 18'd1;
                if (cnt_reg == 18'd1)
                begin
                    mode_next = MODE_CMD;
                end
            end
            MODE_DIRECT:
            begin
                res.action    = ACT_DIRECT;
                res.data_word = in_word_reg;
                cnt_next      = cnt_reg - 18'd1;
                if (cnt_reg == 18'd1)
                begin
                    res.direct_last = 1'b1;
                    mode_next       = MODE_CMD;
                end
            end
            MODE_UNPACK:
            begin
                if (store_reg)
                begin
                    res.action        = ACT_WRITE;
                    res.data_word     = in_word_reg;
                    res.mem_byte_addr = waddr_reg;
                    waddr_next        = waddr_reg + 14'd4;
                end
                else
                begin
                    res.action = ACT_DISCARD;
                end
                cnt_next = cnt_reg - 18'd1;
                if (cnt_reg == 18'd1)
                begin
                    mode_next = MODE_CMD;
                end
            end
            MODE_DROP:
            begin
                res.action = ACT_DISCARD;
            end
            MODE_CMD:
            begin
                res.action        = dec.action;
                res.vu_start_addr = dec.start_addr;
                mode_next         = dec.mode;
                if (dec.load_count)
                begin
                    cnt_next = dec.count;
                end
                if (dec.load_unpack)
                begin
                    waddr_next = dec.unpack_addr;
                    store_next = dec.store_en;
                end
            end
            default:
            begin
                mode_next = MODE_CMD;
            end
        endcase
        // end of packet forgets anything still owed
        if (pkt_end)
        begin
            mode_next  = MODE_CMD;
            cnt_next   = 18'd0;
            store_next = 1'b0;
        end
    end

    // parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_CMD;
            cnt_reg   <= 18'd0;
            waddr_reg <= 14'd0;
            store_reg <= 1'b0;
        end
        else if (advance)
        begin
            mode_reg  <= mode_next;
            cnt_reg   <= cnt_next;
            waddr_reg <= waddr_next;
            store_reg <= store_next;
        end
    end

    // result register
    vucsp_out_stage u_out_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (advance),
        .res_in   (res),
        .can_load (out_free),
        .result   (result)
    );

    // payload modes always owe at least one word
    assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == MODE_SKIP || mode_reg == MODE_DIRECT || mode_reg == MODE_UNPACK)
        |-> cnt_reg != 18'd0)
    else $error("payload mode with zero count");

    // a packet-ending word returns the parser to command decoding
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && pkt_end) |=> (mode_reg == MODE_CMD && !store_reg))
    else $error("parser state survived end of packet");

    // last marker only on direct words
    assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.direct_last) |-> result.action == ACT_DIRECT)
    else $error("direct_last on non-direct result");

    // unpack writes are word aligned
    assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.action == ACT_WRITE) |-> result.mem_byte_addr[1:0] == 2'b00)
    else $error("unaligned unpack write address");

endmodule

@@ design/vucsp_decode.sv @@
// ----------------------------------------------------------------------------
// vucsp_decode
// Command word decoder: works out the action, the next parser mode, the
// payload length and the unpack write address of one command word.
// ----------------------------------------------------------------------------
module vucsp_decode import vucsp_pkg::*; #(
    parameter int unsigned VU_DATA_BYTES = 16384
) (
    input  logic [31:0] word,
    input  logic [17:0] words_left,
    output decode_t     dec
);

    localparam logic [20:0] MEM_LIMIT = 21'(VU_DATA_BYTES);

    logic [6:0]  cmd;
    logic [15:0] imm;
    logic [7:0]  num;
    logic [3:0]  fmt;
    logic [17:0] avail;
    logic [17:0] direct_cnt;
    logic [17:0] reg_cnt;
    logic [12:0] unpack_bytes_total;
    logic [10:0] unpack_cnt;
    logic [19:0] dst;
    logic [20:0] bound;

    // field extraction and payload sizing
    always_comb
    begin
        cmd                = word[30:24] & CMD_FIELD_MASK;
        imm                = word[15:0];
        num                = word[23:16];
        fmt                = cmd[3:0];
        avail              = (words_left == 18'd0) ? 18'd0 : words_left - 18'd1;
        direct_cnt         = {imm, 2'b00};
        reg_cnt            = (cmd == CMD_STMASK) ? MASK_WORDS : ROWCOL_WORDS;
        unpack_bytes_total = 13'(num) * 13'(unpack_bytes(fmt));
        unpack_cnt         = 11'((unpack_bytes_total + 13'd3) >> 2);
        dst                = {imm, 4'b0000};
        bound              = 21'(dst) + 21'({num, 4'b0000});
    end

    // command decode
    always_comb
    begin
        dec        = '0;
        dec.action = ACT_CONSUMED;
        dec.mode   = MODE_CMD;
        unique case (cmd) inside
            CMD_MSCAL, CMD_MSCALF:
            begin
                dec.action     = ACT_VU_START;
                dec.start_addr = {imm, 3'b000};
            end
            CMD_MSCNT:
            begin
                dec.action = ACT_VU_CONT;
            end
            CMD_STMASK, CMD_STROW, CMD_STCOL:
            begin
                if (reg_cnt <= avail)
                begin
                    dec.mode       = MODE_SKIP;
                    dec.load_count = 1'b1;
                    dec.count      = reg_cnt;
                end
            end
            CMD_DIRECT, CMD_DIRECTHL:
            begin
                if (direct_cnt > avail)
                begin
                    dec.mode = MODE_DROP;
                end
                else if (direct_cnt != 18'd0)
                begin
                    dec.mode       = MODE_DIRECT;
                    dec.load_count = 1'b1;
                    dec.count      = direct_cnt;
                end
            end
            [CMD_UNPACK_LO:CMD_UNPACK_HI]:
            begin
                if (unpack_cnt != 11'd0)
                begin
                    dec.mode        = MODE_UNPACK;
                    dec.load_count  = 1'b1;
                    dec.count       = 18'(unpack_cnt);
                    dec.load_unpack = 1'b1;
                    dec.unpack_addr = dst[13:0];
                    dec.store_en    = (18'(unpack_cnt) <= avail) && (fmt == FMT_V4_32)
                                      && (bound <= MEM_LIMIT);
                end
            end
            default:
            begin
                dec.action = ACT_CONSUMED;
            end
        endcase
    end

endmodule

@@ design/vucsp_out_stage.sv @@
// ----------------------------------------------------------------------------
// vucsp_out_stage
// Result register: holds one finished result word until the sink takes it.
// ----------------------------------------------------------------------------
module vucsp_out_stage import vucsp_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  result_t          res_in,
    output logic             can_load,
    vucsp_out_if.source      result
);

    logic    valid_reg;
    result_t res_reg;

    // free when empty or when the held word leaves this cycle
    assign can_load = !valid_reg || result.ready;

    // valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (can_load)
        begin
            valid_reg <= load;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (load && can_load)
        begin
            res_reg <= res_in;
        end
    end

    assign result.valid         = valid_reg;
    assign result.action        = res_reg.action;
    assign result.vu_start_addr = res_reg.vu_start_addr;
    assign result.data_word     = res_reg.data_word;
    assign result.mem_byte_addr = res_reg.mem_byte_addr;
    assign result.direct_last   = res_reg.direct_last;

endmodule
